[rtl/sdmq_pkg.sv]
// Shared types and constants for the supply/demand matching queues.
// No dependencies; used by sdmq_cell and supply_demand_matching_queues.
`timescale 1ns / 1ps

package sdmq_pkg;

  // Fixed field widths
  localparam int STATUS_W  = 3;
  localparam int LIMIT_W   = 4;
  localparam int WREQ_W    = 4;
  localparam int WSRV_W    = 5;

  // Reset value of the request limit register
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd4;

  // Operation codes
  localparam logic OP_SERVER  = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_SERVER_QUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SERVER_MATCHED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REQUEST_SERVED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REQUEST_QUEUED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECTED       = 3'd4;

  // Control broadcast to every cell of the server chain
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

[rtl/sdmq_cell.sv]
// One slot of the server queue chain: holds one identifier and an occupied flag.
// Depends on sdmq_pkg (cell_ctrl_t).
`timescale 1ns / 1ps

module sdmq_cell #(
  parameter int IDENT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sdmq_pkg::cell_ctrl_t  ctrl,
  input  logic [IDENT_BITS-1:0] push_ident,
  input  logic                  prev_occ,
  input  logic                  next_occ,
  input  logic [IDENT_BITS-1:0] next_ident,
  output logic                  occ,
  output logic [IDENT_BITS-1:0] ident
);

  logic                  occ_r;
  logic                  occ_nxt;
  logic [IDENT_BITS-1:0] ident_r;
  logic [IDENT_BITS-1:0] ident_nxt;
  logic                  load;

  // Take the pushed transaction when this is the first empty slot
  assign load = ctrl.push && !occ_r && prev_occ;

  // Shift toward the head on pop, else fill on push, else hold
  always_comb begin
    occ_nxt   = occ_r;
    ident_nxt = ident_r;
    priority if (ctrl.pop) begin
      occ_nxt   = next_occ;
      ident_nxt = next_ident;
    end else if (load) begin
      occ_nxt   = 1'b1;
      ident_nxt = push_ident;
    end else begin
      occ_nxt   = occ_r;
      ident_nxt = ident_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ident_r <= ident_nxt;
  end

  assign occ   = occ_r;
  assign ident = ident_r;

endmodule

[rtl/supply_demand_matching_queues.sv]
// Top level of the supply/demand matching queues: decision logic, request count,
// server queue built as a chain of sdmq_cell slots. Depends on sdmq_pkg, sdmq_cell.
//
//   channel   handshake             payload
//   --------  --------------------  -------------------------------------------
//   input     start / busy          in_operation, in_ident
//   result    out_valid (strobe)    out_status, out_served_ident,
//                                   out_waiting_requests, out_waiting_servers
//   config    cfg_wr_en             cfg_wr_data (request limit)
//
// One transaction per clock; busy stays low. The result appears on the cycle after
// start and stays for exactly one cycle. The whole decision and the queue update
// take effect together: the server chain shifts all slots toward the head at once.
// Synchronous active-low reset empties both queues and sets the limit to 4.
// The receiver cannot stall; every result is taken when out_valid is high.
`timescale 1ns / 1ps

module supply_demand_matching_queues #(
  parameter int SERVER_DEPTH  = 16,
  parameter int REQUEST_DEPTH = 8,
  parameter int IDENT_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic [IDENT_BITS-1:0]           in_ident,
  output logic                            out_valid,
  output logic [sdmq_pkg::STATUS_W-1:0]   out_status,
  output logic [IDENT_BITS-1:0]           out_served_ident,
  output logic [sdmq_pkg::WREQ_W-1:0]     out_waiting_requests,
  output logic [sdmq_pkg::WSRV_W-1:0]     out_waiting_servers,
  input  logic                            cfg_wr_en,
  input  logic [sdmq_pkg::LIMIT_W-1:0]    cfg_wr_data
);

  localparam int SCW = $clog2(SERVER_DEPTH + 1);
  localparam int RCW = $clog2(REQUEST_DEPTH + 1);
  localparam int LW  = (RCW > sdmq_pkg::LIMIT_W) ? RCW : sdmq_pkg::LIMIT_W;
  localparam logic [LW-1:0] REQ_DEPTH_L = LW'(REQUEST_DEPTH);

  // Configuration register
  logic [sdmq_pkg::LIMIT_W-1:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= sdmq_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // Server chain
  sdmq_pkg::cell_ctrl_t            ctrl;
  logic [SERVER_DEPTH-1:0]         occ_w;
  logic [IDENT_BITS-1:0]           ident_w [SERVER_DEPTH];

  for (genvar i = 0; i < SERVER_DEPTH; i++) begin : g_cell
    logic                  prev_occ;
    logic                  next_occ;
    logic [IDENT_BITS-1:0] next_ident;

    if (i == 0) begin : g_first
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_occ = occ_w[i-1];
    end

    if (i == SERVER_DEPTH - 1) begin : g_last
      assign next_occ   = 1'b0;
      assign next_ident = '0;
    end else begin : g_inner
      assign next_occ   = occ_w[i+1];
      assign next_ident = ident_w[i+1];
    end

    sdmq_cell #(
      .IDENT_BITS (IDENT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .push_ident (in_ident),
      .prev_occ   (prev_occ),
      .next_occ   (next_occ),
      .next_ident (next_ident),
      .occ        (occ_w[i]),
      .ident      (ident_w[i])
    );
  end

  // Counters and result registers
  logic [SCW-1:0]                srv_count_r, srv_count_nxt;
  logic [RCW-1:0]                req_count_r, req_count_nxt;
  logic                          valid_r;
  logic [sdmq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [IDENT_BITS-1:0]         served_r, served_nxt;
  logic                          accept;
  logic [LW-1:0]                 limit_ext;
  logic [LW-1:0]                 limit_eff;
  logic                          req_at_limit;

  assign accept    = start && !busy;
  assign limit_ext = LW'(limit_r);
  assign limit_eff = (limit_ext > REQ_DEPTH_L) ? REQ_DEPTH_L : limit_ext;
  assign req_at_limit = LW'(req_count_r) >= limit_eff;

  // Decide the outcome of the arriving transaction
  always_comb begin
    ctrl          = '0;
    srv_count_nxt = srv_count_r;
    req_count_nxt = req_count_r;
    status_nxt    = sdmq_pkg::ST_REJECTED;
    served_nxt    = '0;
    if (in_operation == sdmq_pkg::OP_SERVER) begin
      priority if (req_count_r != '0) begin
        req_count_nxt = req_count_r - RCW'(1);
        status_nxt    = sdmq_pkg::ST_SERVER_MATCHED;
      end else if (occ_w[SERVER_DEPTH-1]) begin
        status_nxt    = sdmq_pkg::ST_REJECTED;
      end else begin
        ctrl.push     = accept;
        srv_count_nxt = srv_count_r + SCW'(1);
        status_nxt    = sdmq_pkg::ST_SERVER_QUEUED;
      end
    end else begin
      priority if (occ_w[0]) begin
        ctrl.pop      = accept;
        served_nxt    = ident_w[0];
        srv_count_nxt = srv_count_r - SCW'(1);
        status_nxt    = sdmq_pkg::ST_REQUEST_SERVED;
      end else if (req_at_limit) begin
        status_nxt    = sdmq_pkg::ST_REJECTED;
      end else begin
        req_count_nxt = req_count_r + RCW'(1);
        status_nxt    = sdmq_pkg::ST_REQUEST_QUEUED;
      end
    end
  end

  // Advance counts and strobe the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srv_count_r <= '0;
      req_count_r <= '0;
      valid_r     <= 1'b0;
    end else begin
      valid_r <= accept;
      if (accept) begin
        srv_count_r <= srv_count_nxt;
        req_count_r <= req_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      served_r <= served_nxt;
    end
  end

  assign busy                 = 1'b0;
  assign out_valid            = valid_r;
  assign out_status           = status_r;
  assign out_served_ident     = served_r;
  assign out_waiting_requests = sdmq_pkg::WREQ_W'(req_count_r);
  assign out_waiting_servers  = sdmq_pkg::WSRV_W'(srv_count_r);

endmodule

[test/sdmq_scoreboard.sv]
// Scoreboard for the supply/demand matching queues: tracks both queues,
// predicts every result and compares it field by field. Depends on sdmq_pkg.
`timescale 1ns / 1ps

module sdmq_scoreboard #(
  parameter int SERVER_DEPTH  = 16,
  parameter int REQUEST_DEPTH = 8,
  parameter int IDENT_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_operation,
  input  logic [IDENT_BITS-1:0]         in_ident,
  input  logic                          out_valid,
  input  logic [sdmq_pkg::STATUS_W-1:0] out_status,
  input  logic [IDENT_BITS-1:0]         out_served_ident,
  input  logic [sdmq_pkg::WREQ_W-1:0]   out_waiting_requests,
  input  logic [sdmq_pkg::WSRV_W-1:0]   out_waiting_servers,
  input  logic                          cfg_wr_en,
  input  logic [sdmq_pkg::LIMIT_W-1:0]  cfg_wr_data,
  output int                            mismatches,
  output int                            outstanding
);

  typedef struct packed {
    logic [sdmq_pkg::STATUS_W-1:0] status;
    logic [IDENT_BITS-1:0]         served_ident;
    logic [sdmq_pkg::WREQ_W-1:0]   waiting_requests;
    logic [sdmq_pkg::WSRV_W-1:0]   waiting_servers;
  } match_result_t;

  // Shadow state of the block
  logic [IDENT_BITS-1:0]        idle_servers[$];
  int                           request_backlog;
  logic [sdmq_pkg::LIMIT_W-1:0] request_limit;
  match_result_t                awaited_results[$];

  // Apply one arrival to the shadow queues and return its result
  function automatic match_result_t match_arrival(logic op, logic [IDENT_BITS-1:0] id);
    match_result_t r;
    int            cap;
    cap = (int'(request_limit) > REQUEST_DEPTH) ? REQUEST_DEPTH : int'(request_limit);
    r.served_ident = '0;
    if (op == sdmq_pkg::OP_SERVER) begin
      if (request_backlog > 0) begin
        // cancel the oldest waiting request, its ident is discarded
        request_backlog--;
        r.status = sdmq_pkg::ST_SERVER_MATCHED;
      end else if (idle_servers.size() >= SERVER_DEPTH) begin
        r.status = sdmq_pkg::ST_REJECTED;
      end else begin
        idle_servers.push_back(id);
        r.status = sdmq_pkg::ST_SERVER_QUEUED;
      end
    end else begin
      if (idle_servers.size() > 0) begin
        r.served_ident = idle_servers.pop_front();
        r.status       = sdmq_pkg::ST_REQUEST_SERVED;
      end else if (request_backlog >= cap) begin
        r.status = sdmq_pkg::ST_REJECTED;
      end else begin
        request_backlog++;
        r.status = sdmq_pkg::ST_REQUEST_QUEUED;
      end
    end
    r.waiting_requests = sdmq_pkg::WREQ_W'(request_backlog);
    r.waiting_servers  = sdmq_pkg::WSRV_W'(idle_servers.size());
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch at %0t: %0s got %0d expected %0d", $time, what, got, want);
  endtask

  // Check the result first, then log the new transaction, then the register write
  always @(posedge clk) begin
    match_result_t want;
    if (!rst_n) begin
      idle_servers.delete();
      awaited_results.delete();
      request_backlog = 0;
      request_limit   = sdmq_pkg::LIMIT_RESET;
      mismatches      = 0;
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_served_ident !== want.served_ident)
            report_mismatch("served_ident", out_served_ident, want.served_ident);
          if (out_waiting_requests !== want.waiting_requests)
            report_mismatch("waiting_requests", out_waiting_requests,
                            want.waiting_requests);
          if (out_waiting_servers !== want.waiting_servers)
            report_mismatch("waiting_servers", out_waiting_servers,
                            want.waiting_servers);
        end
      end
      if (start && !busy)
        awaited_results.push_back(match_arrival(in_operation, in_ident));
      if (cfg_wr_en)
        request_limit = cfg_wr_data;
    end
    outstanding = awaited_results.size();
  end

endmodule

[test/supply_demand_matching_queues_test.sv]
// Top of the matching queues testbench: clock, reset, stimulus and verdict.
// Depends on sdmq_pkg, supply_demand_matching_queues and sdmq_scoreboard.
`timescale 1ns / 1ps

module supply_demand_matching_queues_test;

  localparam int SERVER_DEPTH  = 16;
  localparam int REQUEST_DEPTH = 8;
  localparam int IDENT_BITS    = 16;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          in_operation = sdmq_pkg::OP_SERVER;
  logic [IDENT_BITS-1:0]         in_ident = '0;
  logic                          out_valid;
  logic [sdmq_pkg::STATUS_W-1:0] out_status;
  logic [IDENT_BITS-1:0]         out_served_ident;
  logic [sdmq_pkg::WREQ_W-1:0]   out_waiting_requests;
  logic [sdmq_pkg::WSRV_W-1:0]   out_waiting_servers;
  logic                          cfg_wr_en = 1'b0;
  logic [sdmq_pkg::LIMIT_W-1:0]  cfg_wr_data = '0;
  int                            mismatches;
  int                            outstanding;

  supply_demand_matching_queues #(
    .SERVER_DEPTH (SERVER_DEPTH),
    .REQUEST_DEPTH(REQUEST_DEPTH),
    .IDENT_BITS   (IDENT_BITS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_ident            (in_ident),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_served_ident    (out_served_ident),
    .out_waiting_requests(out_waiting_requests),
    .out_waiting_servers (out_waiting_servers),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  sdmq_scoreboard #(
    .SERVER_DEPTH (SERVER_DEPTH),
    .REQUEST_DEPTH(REQUEST_DEPTH),
    .IDENT_BITS   (IDENT_BITS)
  ) scoreboard (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_ident            (in_ident),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_served_ident    (out_served_ident),
    .out_waiting_requests(out_waiting_requests),
    .out_waiting_servers (out_waiting_servers),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .mismatches          (mismatches),
    .outstanding         (outstanding)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Drive one arrival at the falling edge and hold it until accepted
  task automatic send_arrival(logic op, logic [IDENT_BITS-1:0] id);
    bit taken;
    start        <= 1'b1;
    in_operation <= op;
    in_ident     <= id;
    do begin
      @(posedge clk);
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  // Drop start for a number of cycles
  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Hold off until every expected result has come, then let the pipe settle
  task automatic drain_results();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the request limit while the block is idle
  task automatic write_limit(logic [sdmq_pkg::LIMIT_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  // Random ident with the extremes showing up now and then
  function automatic logic [IDENT_BITS-1:0] pick_ident();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return IDENT_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  // Random traffic in bursts; each burst leans toward servers, requests or neither
  task automatic run_traffic(int count);
    int sent;
    int burst;
    int req_pct;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      case ($urandom_range(0, 2))
        0:       req_pct = 15;
        1:       req_pct = 50;
        default: req_pct = 85;
      endcase
      for (int k = 0; k < burst && sent < count; k++) begin
        send_arrival(($urandom_range(1, 100) <= req_pct) ? sdmq_pkg::OP_REQUEST
                                                         : sdmq_pkg::OP_SERVER,
                     pick_ident());
        sent++;
      end
      if ($urandom_range(0, 29) == 0)
        drain_results();
      else if ($urandom_range(0, 3) != 0)
        idle_cycles($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [sdmq_pkg::LIMIT_W-1:0] limits[7];
    limits = '{4'd0, 4'd8, 4'd15, 4'd1, 4'd9, 4'd2, 4'd6};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset limit of 4, fifth waiting request rejected
    for (int k = 0; k < 5; k++)
      send_arrival(sdmq_pkg::OP_REQUEST, IDENT_BITS'(16'h1000 + k));
    // server arrivals cancel waiting requests, then queue once none are left
    for (int k = 0; k < 4; k++)
      send_arrival(sdmq_pkg::OP_SERVER, IDENT_BITS'(16'h2000 + k));
    send_arrival(sdmq_pkg::OP_SERVER, '1);
    send_arrival(sdmq_pkg::OP_SERVER, '0);
    send_arrival(sdmq_pkg::OP_SERVER, 16'h5aa5);
    // requests take servers oldest first
    send_arrival(sdmq_pkg::OP_REQUEST, '0);
    send_arrival(sdmq_pkg::OP_REQUEST, '1);
    send_arrival(sdmq_pkg::OP_REQUEST, 16'ha55a);
    // empty again: request queued, then cancelled
    send_arrival(sdmq_pkg::OP_REQUEST, 16'h0f0f);
    send_arrival(sdmq_pkg::OP_SERVER, 16'hf0f0);
    drain_results();

    // Limit zero: every unserved request rejected
    write_limit(4'd0);
    send_arrival(sdmq_pkg::OP_REQUEST, 16'h1234);
    send_arrival(sdmq_pkg::OP_REQUEST, '1);
    // fill the server queue and overflow it
    for (int k = 0; k < SERVER_DEPTH + 2; k++)
      send_arrival(sdmq_pkg::OP_SERVER, pick_ident());
    for (int k = 0; k < SERVER_DEPTH + 1; k++)
      send_arrival(sdmq_pkg::OP_REQUEST, pick_ident());
    drain_results();

    // Random phases over several limit settings, extremes included
    foreach (limits[p]) begin
      write_limit(limits[p]);
      run_traffic(235);
      drain_results();
    end

    if (mismatches == 0 && outstanding == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
